>>> rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash engine.
package sha256_pkg;

  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned WINDOW    = 16;
  localparam int unsigned ROUNDS    = 64;

  typedef logic [31:0] word_t;

  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_TAB [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  typedef struct packed {
    logic       push;       // load one block byte
    logic [7:0] data_byte;
    logic [1:0] byte_pos;   // position of the byte inside its word
    logic       advance;    // step the schedule by one round
  } sched_ctrl_t;

  typedef struct packed {
    logic load;   // copy chain value into working variables
    logic round;  // run one compression round
    logic fold;   // add working variables into chain value
    logic init;   // restore initial hash vector
  } core_ctrl_t;

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> rtl/sha256_sched.sv
// Block word window: byte packing during load and message schedule during rounds.
module sha256_sched (
  input  logic                     clk,
  input  sha256_pkg::sched_ctrl_t  ctrl,
  output sha256_pkg::word_t        w_t
);
  import sha256_pkg::*;

  word_t       win_r [WINDOW];
  logic [23:0] acc_r;
  word_t       new_w;

  // W[t+16] from the window holding W[t..t+15]
  assign new_w = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  assign w_t   = win_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (ctrl.byte_pos == 2'd3) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          win_r[i] <= win_r[i + 1];
        end
        win_r[WINDOW - 1] <= {acc_r, ctrl.data_byte};
      end else begin
        acc_r <= {acc_r[15:0], ctrl.data_byte};
      end
    end else if (ctrl.advance) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[WINDOW - 1] <= new_w;
    end
  end

endmodule

>>> rtl/sha256_core.sv
// Compression round unit with working variables and chain value.
module sha256_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha256_pkg::core_ctrl_t  ctrl,
  input  logic [5:0]              rnd,
  input  sha256_pkg::word_t       w_t,
  input  logic [2:0]              rd_idx,
  output sha256_pkg::word_t       rd_word
);
  import sha256_pkg::*;

  word_t chain_r [NUM_WORDS];
  word_t wk_r    [NUM_WORDS];
  word_t t1, t2, ch_v, maj_v;

  assign ch_v  = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
  assign maj_v = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
  assign t1    = wk_r[7] + big_sigma1(wk_r[4]) + ch_v + K_TAB[rnd] + w_t;
  assign t2    = big_sigma0(wk_r[0]) + maj_v;
  assign rd_word = chain_r[rd_idx];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        wk_r[i] <= chain_r[i];
      end
    end else if (ctrl.round) begin
      wk_r[7] <= wk_r[6];
      wk_r[6] <= wk_r[5];
      wk_r[5] <= wk_r[4];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[3] <= wk_r[2];
      wk_r[2] <= wk_r[1];
      wk_r[1] <= wk_r[0];
      wk_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= IV_TAB[i];
      end
    end else if (ctrl.fold) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + wk_r[i];
      end
    end
  end

endmodule

>>> rtl/sha256_hash_engine_top.sv
// SHA-256 hash engine top level: byte intake, padding sequencer and digest output.
//
// Feeds a byte stream one item per transfer and returns the SHA-256 digest as
// eight 32-bit words, word 0 first, the eighth flagged by out_last_word. Byte
// items are taken back to back while in_ready is high; every 64th byte of a
// message starts the 64 rounds of the single round unit plus the chain update,
// during which in_ready is low. An end-of-message item starts padding, which
// pushes one pad or length byte per cycle through the same block path (with a
// second block when the length does not fit), pausing during the rounds of
// each block that fills; then the eight digest words go out at one per cycle
// while out_ready is high. No item is taken while the digest is being delivered;
// after the last word the engine is back at the initial hash vector.
module sha256_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_cnt_r, msg_cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        pad_active_r, pad_active_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        two_blk_r, two_blk_nxt;
  logic        pad_done_r, pad_done_nxt;

  logic        ins;
  logic [7:0]  ins_byte;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [2:0]  len_pos;
  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;
  word_t       w_t;
  word_t       rd_word;

  assign len_bits = {msg_cnt_r, 3'b000};
  assign len_pos  = ~fill_r[2:0];
  assign len_byte = len_bits[{len_pos, 3'b000} +: 8];

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    msg_cnt_nxt    = msg_cnt_r;
    rnd_nxt        = rnd_r;
    out_idx_nxt    = out_idx_r;
    pad_active_nxt = pad_active_r;
    pad_first_nxt  = pad_first_r;
    two_blk_nxt    = two_blk_r;
    pad_done_nxt   = pad_done_r;
    ins            = 1'b0;
    ins_byte       = in_message_byte;
    core_ctrl      = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_byte) begin
            ins         = 1'b1;
            msg_cnt_nxt = msg_cnt_r + 61'd1;
          end
          if (in_end_of_message) begin
            pad_active_nxt = 1'b1;
            pad_first_nxt  = 1'b1;
          end
          if (in_has_byte && fill_r == LAST_POS) begin
            state_nxt = ST_COMP;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ins = 1'b1;
        if (pad_first_r) begin
          ins_byte      = PAD_BYTE;
          pad_first_nxt = 1'b0;
          two_blk_nxt   = (fill_r > LEN_START - 6'd1);
        end else if (!two_blk_r && fill_r >= LEN_START) begin
          ins_byte = len_byte;
          if (fill_r == LAST_POS) begin
            pad_done_nxt = 1'b1;
          end
        end else begin
          ins_byte = 8'h00;
        end
        if (fill_r == LAST_POS) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        core_ctrl.round = 1'b1;
        rnd_nxt         = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        core_ctrl.fold = 1'b1;
        two_blk_nxt    = 1'b0;
        if (pad_done_r) begin
          state_nxt = ST_OUT;
        end else if (pad_active_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          out_idx_nxt = out_idx_r + 3'd1;
          if (out_idx_r == LAST_IDX) begin
            core_ctrl.init = 1'b1;
            msg_cnt_nxt    = '0;
            pad_active_nxt = 1'b0;
            pad_done_nxt   = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ins) begin
      fill_nxt = fill_r + 6'd1;
      // last byte of the block: start compression from the current chain
      if (fill_r == LAST_POS) begin
        core_ctrl.load = 1'b1;
      end
    end
  end

  always_comb begin
    sched_ctrl.push      = ins;
    sched_ctrl.data_byte = ins_byte;
    sched_ctrl.byte_pos  = fill_r[1:0];
    sched_ctrl.advance   = core_ctrl.round;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      msg_cnt_r    <= '0;
      rnd_r        <= '0;
      out_idx_r    <= '0;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      two_blk_r    <= 1'b0;
      pad_done_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      msg_cnt_r    <= msg_cnt_nxt;
      rnd_r        <= rnd_nxt;
      out_idx_r    <= out_idx_nxt;
      pad_active_r <= pad_active_nxt;
      pad_first_r  <= pad_first_nxt;
      two_blk_r    <= two_blk_nxt;
      pad_done_r   <= pad_done_nxt;
    end
  end

  sha256_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_t  (w_t)
  );

  sha256_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (core_ctrl),
    .rnd     (rnd_r),
    .w_t     (w_t),
    .rd_idx  (out_idx_r),
    .rd_word (rd_word)
  );

  assign out_digest_word = rd_word;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == LAST_IDX);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && fill_r == '0))
    else $error("engine not idle and empty after last digest word");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == LAST_RND) |=> (state_r == ST_FOLD && rnd_r == '0))
    else $error("compression did not end after the last round");

  a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |-> (fill_r == '0))
    else $error("chain update with a partly filled block");

endmodule
